// ----- rtl/core/rla_pkg.sv -----
// Package for the room lease allocator: sizes, payload structs, cell and
// controller types. No dependencies; every rtl/core module uses it.
`default_nettype none

package rla_pkg;

    localparam int ROOMS      = 64;
    localparam int TIME_BITS  = 32;
    localparam int ROOM_IDX_W = $clog2(ROOMS);
    localparam int ROOM_NUM_W = $clog2(ROOMS + 1);

    typedef logic [TIME_BITS-1:0]  time_t;
    typedef logic [ROOM_NUM_W-1:0] room_num_t;
    typedef logic [ROOM_IDX_W-1:0] room_idx_t;

    typedef struct packed {
        logic [31:0] arrival_time;
        logic [31:0] departure_time;
    } req_t;

    typedef struct packed {
        logic [6:0] room_number;
        logic [6:0] rooms_opened;
        logic       full_flag;
    } grant_t;

    typedef struct packed {
        logic  valid;
        time_t arrival;
    } token_t;

    typedef struct packed {
        logic  en;
        time_t end_time;
    } cell_wr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ALLOC,
        ST_WRITE
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/rla_cell.sv -----
// One room cell: busy bit and end time, plus one stage of the scan token line.
// Depends on rla_pkg.
`default_nettype none

module rla_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rla_pkg::token_t   token_in,
    output rla_pkg::token_t        token_out,
    input  wire rla_pkg::cell_wr_t wr,
    output logic                   push
);

    logic            token_valid_reg;
    rla_pkg::time_t  arrival_reg;
    logic            busy_reg;
    logic            busy_next;
    rla_pkg::time_t  end_reg;

    assign push      = token_valid_reg && busy_reg && (end_reg < arrival_reg);
    assign token_out = {token_valid_reg, arrival_reg};

    always_comb
    begin
        busy_next = busy_reg;
        if (wr.en)
        begin
            busy_next = 1'b1;
        end
        else if (push)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_valid_reg <= 1'b0;
            busy_reg        <= 1'b0;
        end
        else
        begin
            token_valid_reg <= token_in.valid;
            busy_reg        <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        arrival_reg <= token_in.arrival;
        if (wr.en)
        begin
            end_reg <= wr.end_time;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/rla_free_stack.sv -----
// LIFO of free room numbers with registered pop data and an entry count.
// Depends on rla_pkg.
`default_nettype none

module rla_free_stack (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push_en,
    input  wire rla_pkg::room_num_t push_room,
    input  wire logic               pop_en,
    output rla_pkg::room_num_t      pop_room,
    output rla_pkg::room_num_t      count
);

    rla_pkg::room_num_t mem [rla_pkg::ROOMS];
    rla_pkg::room_num_t count_reg;
    rla_pkg::room_num_t count_next;
    rla_pkg::room_num_t pop_room_reg;
    rla_pkg::room_num_t top_pos;
    logic               do_push;

    assign do_push  = push_en && (count_reg < rla_pkg::room_num_t'(rla_pkg::ROOMS));
    assign top_pos  = count_reg - rla_pkg::room_num_t'(1);
    assign count    = count_reg;
    assign pop_room = pop_room_reg;

    always_comb
    begin
        count_next = count_reg;
        if (do_push)
        begin
            count_next = count_reg + rla_pkg::room_num_t'(1);
        end
        else if (pop_en)
        begin
            count_next = top_pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[count_reg[rla_pkg::ROOM_IDX_W-1:0]] <= push_room;
        end
        if (pop_en)
        begin
            pop_room_reg <= mem[top_pos[rla_pkg::ROOM_IDX_W-1:0]];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/room_lease_allocator_top.sv -----
// Top level of the room lease allocator: controller, row of room cells and
// free stack. Depends on rla_pkg, rla_cell and rla_free_stack.
//
//  channel | signals                          | direction
//  req     | req_valid, req_ready, req        | in  (arrival, departure)
//  grant   | grant_valid, grant_ready, grant  | out (room, opened, full)
//
// After acceptance the scan token walks the cell row one room per cycle; then
// the allocate state pops the free stack, opens a room or flags full, and the
// write state writes the chosen cell.
// Reset clears busy bits, counts and handshake state; no clearing pass.
// A stalled grant holds the controller in its write state; the next request
// is taken in the idle cycle after the grant is loaded.
`default_nettype none

module room_lease_allocator_top (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    input  wire rla_pkg::req_t   req,
    output logic                 grant_valid,
    input  wire logic            grant_ready,
    output rla_pkg::grant_t      grant
);

    rla_pkg::state_t    state_reg;
    rla_pkg::state_t    state_next;
    rla_pkg::room_idx_t scan_cnt_reg;
    rla_pkg::room_idx_t scan_cnt_next;
    rla_pkg::room_num_t opened_reg;
    rla_pkg::room_num_t opened_next;
    rla_pkg::room_num_t room_reg;
    rla_pkg::room_num_t room_next;
    logic               from_stack_reg;
    logic               from_stack_next;
    logic               full_reg;
    logic               full_next;
    rla_pkg::time_t     depart_reg;
    logic               grant_valid_reg;
    logic               grant_valid_next;
    rla_pkg::grant_t    grant_reg;

    logic               accept;
    logic               scan_last;
    logic               pop_en;
    logic               wr_fire;
    logic               out_load;
    rla_pkg::room_num_t room_sel;
    rla_pkg::room_num_t stack_room;
    rla_pkg::room_num_t stack_count;
    rla_pkg::room_num_t push_room;
    logic               any_push;

    rla_pkg::token_t    token [rla_pkg::ROOMS+1];
    logic [rla_pkg::ROOMS-1:0] push_vec;

    assign accept    = req_valid && req_ready;
    assign scan_last = (scan_cnt_reg == rla_pkg::room_idx_t'(rla_pkg::ROOMS - 1));
    assign any_push  = |push_vec;
    assign push_room = rla_pkg::room_num_t'(scan_cnt_reg) + rla_pkg::room_num_t'(1);
    assign room_sel  = from_stack_reg ? stack_room : room_reg;

    assign token[0] = {accept, rla_pkg::time_t'(req.arrival_time)};

    genvar gi;
    generate
        for (gi = 0; gi < rla_pkg::ROOMS; gi++)
        begin : g_cell
            rla_pkg::cell_wr_t cell_wr;

            assign cell_wr = {wr_fire && (room_sel == rla_pkg::room_num_t'(gi + 1)),
                              depart_reg};

            rla_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .token_in  (token[gi]),
                .token_out (token[gi+1]),
                .wr        (cell_wr),
                .push      (push_vec[gi])
            );
        end
    endgenerate

    rla_free_stack u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (any_push),
        .push_room (push_room),
        .pop_en    (pop_en),
        .pop_room  (stack_room),
        .count     (stack_count)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rla_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = rla_pkg::ST_SCAN;
                end
            end
            rla_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = rla_pkg::ST_ALLOC;
                end
            end
            rla_pkg::ST_ALLOC:
            begin
                state_next = rla_pkg::ST_WRITE;
            end
            rla_pkg::ST_WRITE:
            begin
                if (out_load)
                begin
                    state_next = rla_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rla_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        pop_en    = 1'b0;
        wr_fire   = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            rla_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
            end
            rla_pkg::ST_SCAN:
            begin
                req_ready = 1'b0;
            end
            rla_pkg::ST_ALLOC:
            begin
                pop_en = (stack_count != '0);
            end
            rla_pkg::ST_WRITE:
            begin
                wr_fire  = 1'b1;
                out_load = !grant_valid_reg || grant_ready;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        scan_cnt_next   = scan_cnt_reg;
        opened_next     = opened_reg;
        room_next       = room_reg;
        from_stack_next = from_stack_reg;
        full_next       = full_reg;
        if (accept)
        begin
            scan_cnt_next = '0;
        end
        else if (state_reg == rla_pkg::ST_SCAN)
        begin
            scan_cnt_next = scan_cnt_reg + rla_pkg::room_idx_t'(1);
        end
        if (state_reg == rla_pkg::ST_ALLOC)
        begin
            from_stack_next = pop_en;
            full_next       = 1'b0;
            room_next       = '0;
            if (!pop_en)
            begin
                if (opened_reg < rla_pkg::room_num_t'(rla_pkg::ROOMS))
                begin
                    opened_next = opened_reg + rla_pkg::room_num_t'(1);
                    room_next   = opened_reg + rla_pkg::room_num_t'(1);
                end
                else
                begin
                    full_next = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        grant_valid_next = grant_valid_reg;
        if (out_load)
        begin
            grant_valid_next = 1'b1;
        end
        else if (grant_ready)
        begin
            grant_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= rla_pkg::ST_IDLE;
            scan_cnt_reg    <= '0;
            opened_reg      <= '0;
            from_stack_reg  <= 1'b0;
            full_reg        <= 1'b0;
            grant_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            scan_cnt_reg    <= scan_cnt_next;
            opened_reg      <= opened_next;
            from_stack_reg  <= from_stack_next;
            full_reg        <= full_next;
            grant_valid_reg <= grant_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        room_reg <= room_next;
        if (accept)
        begin
            depart_reg <= rla_pkg::time_t'(req.departure_time);
        end
        if (out_load)
        begin
            grant_reg.room_number  <= 7'(room_sel);
            grant_reg.rooms_opened <= 7'(opened_reg);
            grant_reg.full_flag    <= full_reg;
        end
    end

    assign grant_valid = grant_valid_reg;
    assign grant       = grant_reg;

    a_one_push: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(push_vec))
        else $error("more than one cell pushed in a cycle");

    a_push_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        any_push |-> (state_reg == rla_pkg::ST_SCAN))
        else $error("cell pushed outside the scan");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop_en |-> (stack_count != '0))
        else $error("pop from empty free stack");

    a_full_no_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> ((grant_reg.room_number == '0) == grant_reg.full_flag))
        else $error("room number and full flag disagree");

    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == rla_pkg::ST_SCAN) && (scan_cnt_reg == '0)
                   && token[1].valid)
        else $error("scan did not start after accepted item");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for room_lease_allocator_top: drives lease requests
// over valid/ready and checks each grant against an in-bench allocation model.
// Depends on rla_pkg and the room_lease_allocator_top RTL.
`default_nettype none

module testbench;

    localparam int ITEM_TARGET  = 2000;
    localparam int IDLE_PERCENT = 19;
    localparam int STEADY_FIRST = 900;
    localparam int STEADY_LAST  = 1200;

    logic            clk;
    logic            rst_n;
    logic            req_valid;
    logic            req_ready;
    rla_pkg::req_t   req;
    logic            grant_valid;
    logic            grant_ready;
    rla_pkg::grant_t grant;

    rla_pkg::time_t  lease_end [rla_pkg::ROOMS];
    logic            lease_busy [rla_pkg::ROOMS];
    int              vacant_rooms [rla_pkg::ROOMS];
    int              free_depth;
    int              opened_rooms;

    rla_pkg::grant_t expected_grants [$];
    int              items_sent;
    int              mismatches = 0;
    logic            steady;

    room_lease_allocator_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .grant_valid (grant_valid),
        .grant_ready (grant_ready),
        .grant       (grant)
    );

    always #1 clk = ~clk;

    function automatic rla_pkg::grant_t allocate_room(rla_pkg::req_t r);
        rla_pkg::grant_t g;
        int              room;
        g    = '0;
        room = 0;
        for (int k = 0; k < opened_rooms; k++)
        begin
            if (lease_busy[k] && lease_end[k] < r.arrival_time)
            begin
                lease_busy[k] = 1'b0;
                vacant_rooms[free_depth] = k + 1;
                free_depth++;
            end
        end
        if (free_depth > 0)
        begin
            free_depth--;
            room = vacant_rooms[free_depth];
        end
        else if (opened_rooms < rla_pkg::ROOMS)
        begin
            opened_rooms++;
            room = opened_rooms;
        end
        else
        begin
            g.full_flag = 1'b1;
        end
        if (room != 0)
        begin
            lease_busy[room - 1] = 1'b1;
            lease_end[room - 1]  = r.departure_time;
        end
        g.room_number  = 7'(room);
        g.rooms_opened = 7'(opened_rooms);
        return g;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d, want %0d", what, got, want);
        mismatches++;
    endtask

    task automatic check_grant(rla_pkg::grant_t got);
        rla_pkg::grant_t want;
        if (expected_grants.size() == 0)
        begin
            report_mismatch("unexpected grant, room", int'(got.room_number), 0);
            return;
        end
        want = expected_grants.pop_front();
        if (got.room_number !== want.room_number)
            report_mismatch("room_number", int'(got.room_number), int'(want.room_number));
        if (got.rooms_opened !== want.rooms_opened)
            report_mismatch("rooms_opened", int'(got.rooms_opened),
                            int'(want.rooms_opened));
        if (got.full_flag !== want.full_flag)
            report_mismatch("full_flag", int'(got.full_flag), int'(want.full_flag));
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            grant_ready <= 1'b0;
        else
        begin
            if (grant_valid && grant_ready)
                check_grant(grant);
            grant_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    task automatic send_request(logic [31:0] arrival, logic [31:0] departure);
        rla_pkg::req_t   item;
        rla_pkg::grant_t want;
        int              gap;
        item.arrival_time   = arrival;
        item.departure_time = departure;
        steady = (items_sent >= STEADY_FIRST) && (items_sent < STEADY_LAST);
        if (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 4);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do @(posedge clk); while (!req_ready);
        want = allocate_room(item);
        expected_grants = {expected_grants, want};
        items_sent++;
    endtask

    task automatic test_corner_leases();
        send_request(32'd0, 32'd0);
        send_request(32'd0, 32'd5);
        send_request(32'd1, 32'd1);
        send_request(32'd5, 32'd5);
        send_request(32'd5, 32'd9);
        send_request(32'd6, 32'd2);
        send_request(32'd3, 32'd10);
        send_request(32'd2, 32'd4);
        send_request(32'd11, 32'd11);
        send_request(32'd12, 32'd12);
        send_request(32'hFFFF_FFFF, 32'd0);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_request(32'd0, 32'hFFFF_FFFF);
        send_request(32'h8000_0000, 32'h7FFF_FFFF);
        send_request(32'hAAAA_AAAA, 32'h5555_5555);
        send_request(32'h5555_5555, 32'hAAAA_AAAA);
        send_request(32'hFFFF_FFFF, 32'd1);
        send_request(32'd2, 32'd2);
        send_request(32'd2, 32'd3);
    endtask

    task automatic test_full_house();
        logic [31:0] base;
        int          hold;
        int          fill;
        int          drain;
        send_request(32'hFFFF_FFFF, $urandom_range(0, 255));
        base  = $urandom_range(1000, 32'h4000_0000);
        hold  = $urandom_range(200, 100000);
        fill  = rla_pkg::ROOMS + $urandom_range(0, 8);
        drain = $urandom_range(4, 20);
        for (int n = 0; n < fill; n++)
            send_request(base + n, base + hold + $urandom_range(0, 50));
        for (int n = 0; n < drain; n++)
            send_request(base + hold + 4 * n, base + hold + 4 * n + $urandom_range(0, 30));
    endtask

    task automatic test_lease_timeline();
        logic [32:0] now;
        logic [32:0] leave;
        logic [31:0] arrival;
        logic [31:0] departure;
        int          shift;
        int          count;
        shift = $urandom_range(0, 26);
        count = $urandom_range(10, 60);
        now   = {1'b0, $urandom} >> $urandom_range(1, 32);
        if ($urandom_range(0, 1) == 0)
            send_request(32'hFFFF_FFFF, $urandom_range(0, 255));
        for (int n = 0; n < count; n++)
        begin
            now = now + (33'($urandom_range(0, 3)) << shift);
            if (now[32])
                now = 33'h0_FFFF_FFFF;
            arrival = now[31:0];
            if ($urandom_range(0, 15) == 0)
                arrival = arrival - (32'($urandom_range(1, 8)) << shift);
            leave = {1'b0, arrival} + (33'($urandom_range(0, 40)) << shift);
            if (leave > 33'h0_FFFF_FFFE)
                leave = 33'h0_FFFF_FFFE;
            departure = leave[31:0];
            if ($urandom_range(0, 15) == 0)
                departure = arrival - $urandom_range(1, 100);
            send_request(arrival, departure);
        end
    endtask

    task automatic test_noise_requests();
        int count;
        count = $urandom_range(1, 5);
        for (int n = 0; n < count; n++)
            send_request($urandom, $urandom);
    endtask

    initial
    begin
        int pick;
        clk          = 1'b0;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        steady       = 1'b0;
        free_depth   = 0;
        opened_rooms = 0;
        items_sent   = 0;
        for (int k = 0; k < rla_pkg::ROOMS; k++)
        begin
            lease_busy[k]   = 1'b0;
            lease_end[k]    = '0;
            vacant_rooms[k] = 0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_leases();
        while (items_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
                test_full_house();
            else if (pick < 85)
                test_lease_timeline();
            else
                test_noise_requests();
        end

        req_valid <= 1'b0;
        steady = 1'b0;
        while (expected_grants.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("testbench: errors");
        $finish;
    end

endmodule

`default_nettype wire
